### rtl/core/gap_pkg.sv
// Shared types and constants for the Galois automorphism permute core.
// No dependencies; imported by every module of the core.
package gap_pkg;

  localparam int unsigned IDX_W      = 12;
  localparam int unsigned COEF_W     = 64;
  localparam int unsigned LOG_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // Newton steps for the inverse mod 2^12: 3 -> 6 -> 12 -> 24 correct bits.
  localparam int unsigned NEWTON_STEPS = 3;
  localparam int unsigned ITER_W       = 2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG_RING_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GALOIS_ELEMENT = 1'b1;

  localparam logic [LOG_W-1:0] LOG_RESET    = 4'd12;
  localparam logic [IDX_W-1:0] GALOIS_RESET = 12'd1;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  index;
    logic [COEF_W-1:0] coefficient;
  } in_item_t;

  typedef struct packed {
    logic [COEF_W-1:0] read_value;
    logic [IDX_W-1:0]  source_position;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_INV_INIT,
    ST_INV_T,
    ST_INV_X,
    ST_INV_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic cfg_we;
    logic store_we;
    logic s1_load;
    logic out_load;
    logic inv_init;
    logic inv_mul_t;
    logic inv_mul_x;
    logic inv_commit;
  } dp_cmd_t;

endpackage

### rtl/core/gap_ctrl.sv
// Controller: handshakes, fetch pipeline valid bits and the inverse sequencer.
// Depends on gap_pkg; drives the command struct of gap_datapath.
module gap_ctrl
  import gap_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_kind,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  output dp_cmd_t cmd
);

  ctrl_state_t         state_r, state_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic                s1_valid_r, s1_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                advance;
  logic                in_fire;
  logic                cfg_fire;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != ST_RUN) || (s1_valid_r && !advance);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_RUN);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_RUN: begin
        if (cfg_fire) begin
          state_nxt = ST_INV_INIT;
        end
      end
      ST_INV_INIT: begin
        iter_nxt  = '0;
        state_nxt = ST_INV_T;
      end
      ST_INV_T: begin
        state_nxt = ST_INV_X;
      end
      ST_INV_X: begin
        if (iter_r == ITER_W'(NEWTON_STEPS - 1)) begin
          state_nxt = ST_INV_DONE;
        end else begin
          iter_nxt  = iter_r + ITER_W'(1);
          state_nxt = ST_INV_T;
        end
      end
      ST_INV_DONE: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.cfg_we     = cfg_fire;
    cmd.store_we   = in_fire && (in_kind == KIND_LOAD);
    cmd.s1_load    = in_fire && (in_kind == KIND_FETCH);
    cmd.out_load   = advance;
    case (state_r)
      ST_INV_INIT: cmd.inv_init   = 1'b1;
      ST_INV_T:    cmd.inv_mul_t  = 1'b1;
      ST_INV_X:    cmd.inv_mul_x  = 1'b1;
      ST_INV_DONE: cmd.inv_commit = 1'b1;
      default:     cmd.inv_init   = 1'b0;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (cmd.s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      iter_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/core/gap_datapath.sv
// Datapath: config registers, inverse Newton unit, coefficient store,
// index multiplier and output register. Depends on gap_pkg.
module gap_datapath
  import gap_pkg::*;
#(
  parameter int unsigned MAX_LOG_N = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  output out_item_t             out_data
);

  localparam int unsigned AW    = (MAX_LOG_N < IDX_W) ? MAX_LOG_N : IDX_W;
  localparam int unsigned DEPTH = 1 << AW;

  logic [LOG_W-1:0]  log_r;
  logic [IDX_W-1:0]  gal_r;
  logic [IDX_W-1:0]  inv_r;
  logic [IDX_W-1:0]  x_r;
  logic [IDX_W-1:0]  t_r;
  logic [IDX_W-1:0]  s1_src_r;
  logic [COEF_W-1:0] out_value_r;
  logic [IDX_W-1:0]  out_pos_r;

  logic [4:0]         lg_eff;
  logic [IDX_W-1:0]   mask;
  logic [IDX_W-1:0]   k_eff;
  logic [IDX_W-1:0]   idx_m;
  logic [2*IDX_W-1:0] fetch_prod;
  logic [2*IDX_W-1:0] t_prod;
  logic [2*IDX_W-1:0] x_prod;
  logic [IDX_W-1:0]   src;

  logic [COEF_W-1:0] store_mem [DEPTH];

  // Ring mask from the clamped log size
  always_comb begin
    lg_eff = (5'(log_r) > 5'(MAX_LOG_N)) ? 5'(MAX_LOG_N) : 5'(log_r);
    for (int j = 0; j < IDX_W; j++) begin
      mask[j] = (5'(j) < lg_eff);
    end
  end

  assign k_eff      = gal_r & mask;
  assign idx_m      = in_data.index & mask;
  assign fetch_prod = idx_m * inv_r;
  assign src        = fetch_prod[IDX_W-1:0] & mask;
  assign t_prod     = k_eff * x_r;
  assign x_prod     = x_r * (IDX_W'(2) - t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_r <= LOG_RESET;
      gal_r <= GALOIS_RESET;
      inv_r <= IDX_W'(1);
    end else begin
      if (cmd.cfg_we) begin
        case (cfg_index)
          CFG_LOG_RING_SIZE:  log_r <= cfg_data[LOG_W-1:0];
          CFG_GALOIS_ELEMENT: gal_r <= cfg_data;
          default:            log_r <= log_r;
        endcase
      end
      if (cmd.inv_commit) begin
        inv_r <= k_eff[0] ? (x_r & mask) : '0;
      end
    end
  end

  // Newton iteration x <- x * (2 - k*x), one multiply per cycle
  always_ff @(posedge clk) begin
    if (cmd.inv_init) begin
      x_r <= k_eff;
    end else if (cmd.inv_mul_x) begin
      x_r <= x_prod[IDX_W-1:0];
    end
    if (cmd.inv_mul_t) begin
      t_r <= t_prod[IDX_W-1:0];
    end
  end

  // Store: write on load, read for the fetch in stage one (old data on collision)
  always_ff @(posedge clk) begin
    if (cmd.store_we) begin
      store_mem[idx_m[AW-1:0]] <= in_data.coefficient;
    end
    if (cmd.out_load) begin
      out_value_r <= store_mem[s1_src_r[AW-1:0]];
      out_pos_r   <= s1_src_r;
    end
    if (cmd.s1_load) begin
      s1_src_r <= src;
    end
  end

  assign out_data.read_value      = out_value_r;
  assign out_data.source_position = out_pos_r;

endmodule

### rtl/core/galois_automorphism_permute_core.sv
// Top level of the Galois automorphism permute core.
// Depends on gap_pkg, gap_ctrl and gap_datapath.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | input     | in_valid/in_stall  | in_item_t  (kind, index, coef)
//   out_    | output    | out_valid/out_stall| out_item_t (value, source pos)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load writes the coefficient to the store at the accept edge. A fetch
// multiplies the masked index by the stored inverse at accept into the
// stage-one register, then reads the store into the output register when
// the output can advance; one item per cycle is sustained while out_stall
// is low and no configuration is in progress. There is one index multiplier.
// A configuration transfer recomputes the inverse in 3 Newton steps of two
// multiplies each, plus setup and commit; inputs stall meanwhile.
// Reset sets log_ring_size 12, galois_element 1, inverse 1; the store is not
// cleared. out_stall holds the output register and backs up into in_stall.
module galois_automorphism_permute_core
  import gap_pkg::*;
#(
  parameter int unsigned MAX_LOG_N = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  // Sequence handshakes and the inverse computation
  gap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Hold config, store and permute indices
  gap_datapath #(
    .MAX_LOG_N (MAX_LOG_N)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data)
  );

endmodule
